// File: rtl/spi_pkg.sv
// shared constants, types and helpers for the segment pair intersection block
`timescale 1ns / 1ps

package spi_pkg;

  // coordinate and fixed point format
  localparam int CB = 16;               // coordinate bits
  localparam int FB = 16;               // output fraction bits
  localparam int OW = 32;               // output point width
  localparam int CW = 32;               // configuration register width
  localparam int NEAR_BITS = 16;        // snap window, per axis, in output lsb bits

  // derived datapath widths
  localparam int DW = CB + 1;           // coordinate difference
  localparam int PW = 2 * DW;           // product of two differences
  localparam int SW = PW + 1;           // sum of two products
  localparam int MW = 2 * CB + 1;       // magnitude of a cross product or squared length
  localparam int TW = 2 * MW + CW;      // tolerance compare width
  localparam int QW = CB + FB;          // quotient of the crossing offset
  localparam int NW = MW + CB + FB;     // dividend of the crossing offset
  localparam int PX = CB + FB + 2;      // unsaturated output point

  // divider pipeline: quotient bits resolved per stage and stage count
  localparam int BPS = 4;
  localparam int DS  = (QW + BPS - 1) / BPS;

  // configuration register indexes
  localparam int IW = 1;
  localparam logic [IW-1:0] REG_PAR_TOL  = 1'd0;
  localparam logic [IW-1:0] REG_SNAP_DSQ = 1'd1;

  // register reset values
  localparam logic [CW-1:0] PAR_TOL_RST  = 32'd429;
  localparam logic [CW-1:0] SNAP_DSQ_RST = 32'd1;

  // hit codes
  localparam logic [1:0] HIT_NONE    = 2'd0;
  localparam logic [1:0] HIT_POINT   = 2'd1;
  localparam logic [1:0] HIT_OVERLAP = 2'd2;

  // both segments of one item
  typedef struct packed {
    logic signed [CB-1:0] ax0;
    logic signed [CB-1:0] ay0;
    logic signed [CB-1:0] ax1;
    logic signed [CB-1:0] ay1;
    logic signed [CB-1:0] bx0;
    logic signed [CB-1:0] by0;
    logic signed [CB-1:0] bx1;
    logic signed [CB-1:0] by1;
  } pts_t;

  // decision that travels alongside the divider
  typedef struct packed {
    logic [1:0] hit;
    logic       crossing; // point comes from the crossing
    logic       end_a1;   // endpoint result is a_end, else a_start
    logic       negx;
    logic       negy;
    pts_t       pts;
  } side_t;

  // sign extend a coordinate to difference width
  function automatic logic signed [DW-1:0] dext(input logic signed [CB-1:0] v);
    return $signed({v[CB-1], v});
  endfunction

endpackage

// File: rtl/spi_in_if.sv
// segment pair item channel
`timescale 1ns / 1ps

interface spi_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [spi_pkg::CB-1:0]  a_start_x;
  logic signed [spi_pkg::CB-1:0]  a_start_y;
  logic signed [spi_pkg::CB-1:0]  a_end_x;
  logic signed [spi_pkg::CB-1:0]  a_end_y;
  logic signed [spi_pkg::CB-1:0]  b_start_x;
  logic signed [spi_pkg::CB-1:0]  b_start_y;
  logic signed [spi_pkg::CB-1:0]  b_end_x;
  logic signed [spi_pkg::CB-1:0]  b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

// File: rtl/spi_out_if.sv
// intersection result item channel
`timescale 1ns / 1ps

interface spi_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     hit_count;
  logic signed [spi_pkg::OW-1:0]  point_x;
  logic signed [spi_pkg::OW-1:0]  point_y;

  modport source (output valid, hit_count, point_x, point_y, input ready);
  modport sink (input valid, hit_count, point_x, point_y, output ready);
endinterface

// File: rtl/spi_front.sv
// front pipeline: differences, products, tolerance tests and classification
`timescale 1ns / 1ps

module spi_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  spi_pkg::pts_t              pts_i,
  input  logic [spi_pkg::CW-1:0]     tol_i,
  output logic                       valid_o,
  output spi_pkg::side_t             side_o,
  output logic [spi_pkg::NW-1:0]     num_x_o,
  output logic [spi_pkg::NW-1:0]     num_y_o,
  output logic [spi_pkg::MW-1:0]     den_o
);

  localparam int NST = 7;

  logic [NST-1:0] v_q;

  // stage 1: coordinate differences
  spi_pkg::pts_t                   pts1_q;
  logic signed [spi_pkg::DW-1:0]   dax1_q, day1_q, dbx1_q, dby1_q;
  logic signed [spi_pkg::DW-1:0]   ex1_q, ey1_q, fx1_q, fy1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts1_q <= pts_i;
      dax1_q <= spi_pkg::dext(pts_i.ax1) - spi_pkg::dext(pts_i.ax0);
      day1_q <= spi_pkg::dext(pts_i.ay1) - spi_pkg::dext(pts_i.ay0);
      dbx1_q <= spi_pkg::dext(pts_i.bx1) - spi_pkg::dext(pts_i.bx0);
      dby1_q <= spi_pkg::dext(pts_i.by1) - spi_pkg::dext(pts_i.by0);
      ex1_q  <= spi_pkg::dext(pts_i.bx0) - spi_pkg::dext(pts_i.ax0);
      ey1_q  <= spi_pkg::dext(pts_i.by0) - spi_pkg::dext(pts_i.ay0);
      fx1_q  <= spi_pkg::dext(pts_i.bx1) - spi_pkg::dext(pts_i.ax0);
      fy1_q  <= spi_pkg::dext(pts_i.by1) - spi_pkg::dext(pts_i.ay0);
    end
  end

  // stage 2: pairwise products
  spi_pkg::pts_t                   pts2_q;
  logic signed [spi_pkg::DW-1:0]   dax2_q, day2_q;
  logic signed [spi_pkg::PW-1:0]   kab2_q, kba2_q, la1_q, la2_q, lb1_q, lb2_q, le1_q, le2_q;
  logic signed [spi_pkg::PW-1:0]   sn1_q, sn2_q, tn1_q, tn2_q, p01_q, p02_q, p11_q, p12_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts2_q <= pts1_q;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      kab2_q <= dax1_q * dby1_q;
      kba2_q <= day1_q * dbx1_q;
      la1_q  <= dax1_q * dax1_q;
      la2_q  <= day1_q * day1_q;
      lb1_q  <= dbx1_q * dbx1_q;
      lb2_q  <= dby1_q * dby1_q;
      le1_q  <= ex1_q * ex1_q;
      le2_q  <= ey1_q * ey1_q;
      sn1_q  <= ex1_q * dby1_q;
      sn2_q  <= ey1_q * dbx1_q;
      tn1_q  <= ex1_q * day1_q;
      tn2_q  <= ey1_q * dax1_q;
      p01_q  <= dax1_q * ex1_q;
      p02_q  <= day1_q * ey1_q;
      p11_q  <= dax1_q * fx1_q;
      p12_q  <= day1_q * fy1_q;
    end
  end

  // stage 3: cross products, squared lengths and projections
  spi_pkg::pts_t                   pts3_q;
  logic signed [spi_pkg::DW-1:0]   dax3_q, day3_q;
  logic signed [spi_pkg::SW-1:0]   kr3_q, sn3_q, tn3_q, p03_q, p13_q;
  logic [spi_pkg::MW-1:0]          la3_q, lb3_q, le3_q;
  logic signed [spi_pkg::SW-1:0]   la_sum, lb_sum, le_sum;

  always_comb begin
    la_sum = spi_pkg::SW'(la1_q) + spi_pkg::SW'(la2_q);
    lb_sum = spi_pkg::SW'(lb1_q) + spi_pkg::SW'(lb2_q);
    le_sum = spi_pkg::SW'(le1_q) + spi_pkg::SW'(le2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts3_q <= pts2_q;
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      kr3_q  <= spi_pkg::SW'(kab2_q) - spi_pkg::SW'(kba2_q);
      sn3_q  <= spi_pkg::SW'(sn1_q) - spi_pkg::SW'(sn2_q);
      tn3_q  <= spi_pkg::SW'(tn1_q) - spi_pkg::SW'(tn2_q);
      p03_q  <= spi_pkg::SW'(p01_q) + spi_pkg::SW'(p02_q);
      p13_q  <= spi_pkg::SW'(p11_q) + spi_pkg::SW'(p12_q);
      la3_q  <= la_sum[spi_pkg::MW-1:0];
      lb3_q  <= lb_sum[spi_pkg::MW-1:0];
      le3_q  <= le_sum[spi_pkg::MW-1:0];
    end
  end

  // stage 4: magnitudes and sign normalization by the cross product
  spi_pkg::pts_t                   pts4_q;
  logic [spi_pkg::MW-1:0]          kmag4_q, cmag4_q, la4_q, lb4_q, le4_q;
  logic signed [spi_pkg::SW-1:0]   sn4_q, tn4_q, p04_q, p14_q;
  logic [spi_pkg::CB-1:0]          adx4_q, ady4_q;
  logic                            negx4_q, negy4_q;
  logic signed [spi_pkg::SW-1:0]   kr_abs, tn_abs;
  logic signed [spi_pkg::DW-1:0]   dax_abs, day_abs;

  always_comb begin
    kr_abs  = kr3_q[spi_pkg::SW-1] ? -kr3_q : kr3_q;
    tn_abs  = tn3_q[spi_pkg::SW-1] ? -tn3_q : tn3_q;
    dax_abs = dax3_q[spi_pkg::DW-1] ? -dax3_q : dax3_q;
    day_abs = day3_q[spi_pkg::DW-1] ? -day3_q : day3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts4_q  <= pts3_q;
      kmag4_q <= kr_abs[spi_pkg::MW-1:0];
      cmag4_q <= tn_abs[spi_pkg::MW-1:0];
      sn4_q   <= kr3_q[spi_pkg::SW-1] ? -sn3_q : sn3_q;
      tn4_q   <= kr3_q[spi_pkg::SW-1] ? -tn3_q : tn3_q;
      p04_q   <= p03_q;
      p14_q   <= p13_q;
      la4_q   <= la3_q;
      lb4_q   <= lb3_q;
      le4_q   <= le3_q;
      adx4_q  <= dax_abs[spi_pkg::CB-1:0];
      ady4_q  <= day_abs[spi_pkg::CB-1:0];
      negx4_q <= dax3_q[spi_pkg::DW-1];
      negy4_q <= day3_q[spi_pkg::DW-1];
    end
  end

  // stage 5: squares for the tolerance tests, offset numerators, range checks
  spi_pkg::pts_t                   pts5_q;
  logic [2*spi_pkg::MW-1:0]        c25_q, c35_q, pq15_q, pq25_q;
  logic [spi_pkg::MW+spi_pkg::CB-1:0] mx5_q, my5_q;
  logic [spi_pkg::MW-1:0]          den5_q, la5_q;
  logic signed [spi_pkg::SW-1:0]   plo5_q, phi5_q;
  logic                            inside5_q, negx5_q, negy5_q;
  logic signed [spi_pkg::SW-1:0]   kmag_s;

  always_comb begin
    kmag_s = $signed({2'b00, kmag4_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts5_q    <= pts4_q;
      c25_q     <= kmag4_q * kmag4_q;
      c35_q     <= cmag4_q * cmag4_q;
      pq15_q    <= la4_q * lb4_q;
      pq25_q    <= la4_q * le4_q;
      mx5_q     <= sn4_q[spi_pkg::MW-1:0] * adx4_q;
      my5_q     <= sn4_q[spi_pkg::MW-1:0] * ady4_q;
      den5_q    <= kmag4_q;
      la5_q     <= la4_q;
      plo5_q    <= (p04_q < p14_q) ? p04_q : p14_q;
      phi5_q    <= (p04_q < p14_q) ? p14_q : p04_q;
      inside5_q <= !sn4_q[spi_pkg::SW-1] && (sn4_q <= kmag_s) &&
                   !tn4_q[spi_pkg::SW-1] && (tn4_q <= kmag_s);
      negx5_q   <= negx4_q;
      negy5_q   <= negy4_q;
    end
  end

  // stage 6: tolerance partial products and overlap flags
  localparam int TPW = spi_pkg::CW + spi_pkg::MW;

  spi_pkg::pts_t                   pts6_q;
  logic [2*spi_pkg::MW-1:0]        c26_q, c36_q;
  logic [TPW-1:0]                  t1lo6_q, t1hi6_q, t2lo6_q, t2hi6_q;
  logic [spi_pkg::MW+spi_pkg::CB-1:0] mx6_q, my6_q;
  logic [spi_pkg::MW-1:0]          den6_q;
  logic                            inside6_q, negx6_q, negy6_q, la_nz6_q;
  logic                            none6_q, lo_end6_q, hi_zero6_q;
  logic signed [spi_pkg::SW-1:0]   len_s;

  always_comb begin
    len_s = $signed({2'b00, la5_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pts6_q     <= pts5_q;
      c26_q      <= c25_q;
      c36_q      <= c35_q;
      t1lo6_q    <= tol_i * pq15_q[spi_pkg::MW-1:0];
      t1hi6_q    <= tol_i * pq15_q[2*spi_pkg::MW-1:spi_pkg::MW];
      t2lo6_q    <= tol_i * pq25_q[spi_pkg::MW-1:0];
      t2hi6_q    <= tol_i * pq25_q[2*spi_pkg::MW-1:spi_pkg::MW];
      mx6_q      <= mx5_q;
      my6_q      <= my5_q;
      den6_q     <= den5_q;
      inside6_q  <= inside5_q;
      negx6_q    <= negx5_q;
      negy6_q    <= negy5_q;
      la_nz6_q   <= (la5_q != '0);
      none6_q    <= (plo5_q > len_s) || phi5_q[spi_pkg::SW-1];
      lo_end6_q  <= (plo5_q == len_s);
      hi_zero6_q <= (phi5_q == '0);
    end
  end

  // stage 7: tolerance compares and classification
  logic [spi_pkg::TW-1:0] lhs1, rhs1, lhs2, rhs2;
  logic                   beyond1, beyond2;
  spi_pkg::side_t         side_d;

  always_comb begin
    lhs1    = {c26_q, spi_pkg::CW'(0)};
    lhs2    = {c36_q, spi_pkg::CW'(0)};
    rhs1    = spi_pkg::TW'(t1lo6_q) + (spi_pkg::TW'(t1hi6_q) << spi_pkg::MW);
    rhs2    = spi_pkg::TW'(t2lo6_q) + (spi_pkg::TW'(t2hi6_q) << spi_pkg::MW);
    beyond1 = lhs1 > rhs1;
    beyond2 = lhs2 > rhs2;

    side_d        = '0;
    side_d.pts    = pts6_q;
    side_d.negx   = negx6_q;
    side_d.negy   = negy6_q;
    side_d.hit    = spi_pkg::HIT_NONE;
    if (beyond1) begin
      // lines cross: a point when both parameters lie in the unit range
      side_d.crossing = 1'b1;
      if (inside6_q) begin
        side_d.hit = spi_pkg::HIT_POINT;
      end
    end else if (la_nz6_q && !beyond2) begin
      // collinear: compare projected ends of b with segment a
      if (none6_q) begin
        side_d.hit = spi_pkg::HIT_NONE;
      end else if (lo_end6_q) begin
        side_d.hit    = spi_pkg::HIT_POINT;
        side_d.end_a1 = 1'b1;
      end else if (hi_zero6_q) begin
        side_d.hit    = spi_pkg::HIT_POINT;
      end else begin
        side_d.hit    = spi_pkg::HIT_OVERLAP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o  <= side_d;
      num_x_o <= {mx6_q, spi_pkg::FB'(0)};
      num_y_o <= {my6_q, spi_pkg::FB'(0)};
      den_o   <= den6_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  assign valid_o = v_q[NST-1];

endmodule

// File: rtl/spi_div.sv
// pipelined restoring divider for the crossing offset, several quotient bits per stage
`timescale 1ns / 1ps

module spi_div (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [spi_pkg::NW-1:0]  num_i,
  input  logic [spi_pkg::MW-1:0]  den_i,
  output logic [spi_pkg::QW-1:0]  quo_o,
  output logic                    rem_nz_o
);

  localparam int DS  = spi_pkg::DS;
  localparam int BPS = spi_pkg::BPS;
  localparam int QW  = spi_pkg::QW;
  localparam int MW  = spi_pkg::MW;
  localparam int NW  = spi_pkg::NW;

  logic [MW-1:0] rem_q [DS];
  logic [QW-1:0] quo_q [DS];
  logic [QW-1:0] low_q [DS];
  logic [MW-1:0] den_q [DS];

  for (genvar s = 0; s < DS; s++) begin : g_stage
    logic [MW-1:0] rem_in, rem_d, den_in;
    logic [QW-1:0] quo_in, quo_d, low_in;

    // the top dividend bits start below the divisor since the quotient fits QW bits
    if (s == 0) begin : g_first
      assign rem_in = num_i[NW-1:QW];
      assign quo_in = '0;
      assign low_in = num_i[QW-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
    end

    // resolve this stage's quotient bits
    always_comb begin
      logic [MW:0] trial;
      int          idx;
      rem_d = rem_in;
      quo_d = quo_in;
      trial = '0;
      idx   = 0;
      for (int j = 0; j < BPS; j++) begin
        idx = QW - 1 - (s * BPS + j);
        if (idx >= 0) begin
          trial = {rem_d, low_in[idx]};
          if (trial >= {1'b0, den_in}) begin
            trial      = trial - {1'b0, den_in};
            quo_d[idx] = 1'b1;
          end
          rem_d = trial[MW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        low_q[s] <= low_in;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o    = quo_q[DS-1];
  assign rem_nz_o = (rem_q[DS-1] != '0);

endmodule

// File: rtl/spi_snap.sv
// back pipeline: crossing point, snap to nearby endpoints, saturation
`timescale 1ns / 1ps

module spi_snap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  spi_pkg::side_t                side_i,
  input  logic [spi_pkg::QW-1:0]        quo_x_i,
  input  logic                          rnz_x_i,
  input  logic [spi_pkg::QW-1:0]        quo_y_i,
  input  logic                          rnz_y_i,
  input  logic [spi_pkg::CW-1:0]        snap_i,
  output logic                          valid_o,
  output logic [1:0]                    hit_o,
  output logic signed [spi_pkg::OW-1:0] x_o,
  output logic signed [spi_pkg::OW-1:0] y_o
);

  localparam int PX = spi_pkg::PX;
  localparam int DX = PX + 1;
  localparam int NB = spi_pkg::NEAR_BITS;

  // coordinate scaled to the output fraction
  function automatic logic signed [PX-1:0] scale(input logic signed [spi_pkg::CB-1:0] v);
    return PX'(v) <<< spi_pkg::FB;
  endfunction

  // clamp to the signed output range
  function automatic logic signed [spi_pkg::OW-1:0] sat(input logic signed [PX-1:0] v);
    logic signed [PX-1:0] hi_lim, lo_lim;
    hi_lim = PX'({1'b0, {(spi_pkg::OW-1){1'b1}}});
    lo_lim = -hi_lim - PX'(1);
    if (v > hi_lim) return spi_pkg::OW'(hi_lim);
    if (v < lo_lim) return spi_pkg::OW'(lo_lim);
    return v[spi_pkg::OW-1:0];
  endfunction

  // stage a: crossing point and its distance to each endpoint
  logic signed [PX-1:0] offx, offy, px_d, py_d;
  logic signed [PX-1:0] bx [4];
  logic signed [PX-1:0] by [4];
  logic signed [DX-1:0] ddx, ddy;
  logic [DX-1:0]        mdx, mdy;
  logic [NB-1:0]        dxl_d [4];
  logic [NB-1:0]        dyl_d [4];
  logic [3:0]           ok_d;

  always_comb begin
    offx = side_i.negx ? -(PX'(quo_x_i) + PX'(rnz_x_i)) : PX'(quo_x_i);
    offy = side_i.negy ? -(PX'(quo_y_i) + PX'(rnz_y_i)) : PX'(quo_y_i);
    px_d = scale(side_i.pts.ax0) + offx;
    py_d = scale(side_i.pts.ay0) + offy;
    bx[0] = scale(side_i.pts.ax0);
    by[0] = scale(side_i.pts.ay0);
    bx[1] = scale(side_i.pts.ax1);
    by[1] = scale(side_i.pts.ay1);
    bx[2] = scale(side_i.pts.bx0);
    by[2] = scale(side_i.pts.by0);
    bx[3] = scale(side_i.pts.bx1);
    by[3] = scale(side_i.pts.by1);
    ddx = '0;
    ddy = '0;
    mdx = '0;
    mdy = '0;
    for (int j = 0; j < 4; j++) begin
      ddx      = DX'(px_d) - DX'(bx[j]);
      ddy      = DX'(py_d) - DX'(by[j]);
      mdx      = ddx[DX-1] ? DX'(-ddx) : DX'(ddx);
      mdy      = ddy[DX-1] ? DX'(-ddy) : DX'(ddy);
      dxl_d[j] = mdx[NB-1:0];
      dyl_d[j] = mdy[NB-1:0];
      ok_d[j]  = (mdx[DX-1:NB] == '0) && (mdy[DX-1:NB] == '0);
    end
  end

  logic                 va_q;
  spi_pkg::side_t       sa_q;
  logic signed [PX-1:0] pxa_q, pya_q;
  logic [NB-1:0]        dxa_q [4];
  logic [NB-1:0]        dya_q [4];
  logic [3:0]           oka_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q  <= side_i;
      pxa_q <= px_d;
      pya_q <= py_d;
      dxa_q <= dxl_d;
      dya_q <= dyl_d;
      oka_q <= ok_d;
    end
  end

  // stage b: squared distances, first near endpoint wins, output select
  logic [2*NB:0]        dsq;
  logic [3:0]           near;
  logic signed [PX-1:0] ox, oy;

  always_comb begin
    dsq  = '0;
    for (int j = 0; j < 4; j++) begin
      dsq     = (2*NB+1)'(dxa_q[j] * dxa_q[j]) + (2*NB+1)'(dya_q[j] * dya_q[j]);
      near[j] = oka_q[j] && ((2*NB+2)'(dsq) < (2*NB+2)'(snap_i));
    end
    ox = '0;
    oy = '0;
    if (sa_q.hit == spi_pkg::HIT_POINT) begin
      if (!sa_q.crossing) begin
        ox = sa_q.end_a1 ? scale(sa_q.pts.ax1) : scale(sa_q.pts.ax0);
        oy = sa_q.end_a1 ? scale(sa_q.pts.ay1) : scale(sa_q.pts.ay0);
      end else if (near[0]) begin
        ox = scale(sa_q.pts.ax0);
        oy = scale(sa_q.pts.ay0);
      end else if (near[1]) begin
        ox = scale(sa_q.pts.ax1);
        oy = scale(sa_q.pts.ay1);
      end else if (near[2]) begin
        ox = scale(sa_q.pts.bx0);
        oy = scale(sa_q.pts.by0);
      end else if (near[3]) begin
        ox = scale(sa_q.pts.bx1);
        oy = scale(sa_q.pts.by1);
      end else begin
        ox = pxa_q;
        oy = pya_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o <= sa_q.hit;
      x_o   <= sat(ox);
      y_o   <= sat(oy);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      valid_o <= va_q;
    end
  end

endmodule

// File: rtl/segment_pair_intersection.sv
// top level of the segment pair intersection pipeline
`timescale 1ns / 1ps

// Segment pair intersection. Takes one segment pair per cycle unless the output
// stalls and returns one result item per pair through seven front stages
// (differences, products, exact squared-sine tolerance tests, classification),
// eight divider stages that each resolve four bits of the Q16.16 crossing offset
// for x and y in parallel, and two stages for the crossing point, endpoint snap
// and saturation; the last stage is the output register. The whole pipeline
// advances together and holds while a result waits on a stalled output, so ready
// follows the output side in the same cycle. The user must write the tolerance
// and snap registers, read live, only while the pipeline is empty (unenforced).
module segment_pair_intersection (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  spi_in_if.sink                   pair_i,
  spi_out_if.source                result_o,
  input  logic                     cfg_we_i,
  input  logic [spi_pkg::IW-1:0]   cfg_idx_i,
  input  logic [spi_pkg::CW-1:0]   cfg_data_i
);

  logic [spi_pkg::CW-1:0] par_tol_q, snap_dsq_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_tol_q  <= spi_pkg::PAR_TOL_RST;
      snap_dsq_q <= spi_pkg::SNAP_DSQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spi_pkg::REG_PAR_TOL:  par_tol_q  <= cfg_data_i;
        spi_pkg::REG_SNAP_DSQ: snap_dsq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: move unless a finished item is stuck at the output
  logic en;
  assign en           = !result_o.valid || result_o.ready;
  assign pair_i.ready = en;

  spi_pkg::pts_t pts_in;
  always_comb begin
    pts_in.ax0 = pair_i.a_start_x;
    pts_in.ay0 = pair_i.a_start_y;
    pts_in.ax1 = pair_i.a_end_x;
    pts_in.ay1 = pair_i.a_end_y;
    pts_in.bx0 = pair_i.b_start_x;
    pts_in.by0 = pair_i.b_start_y;
    pts_in.bx1 = pair_i.b_end_x;
    pts_in.by1 = pair_i.b_end_y;
  end

  logic                   fr_valid;
  spi_pkg::side_t         fr_side;
  logic [spi_pkg::NW-1:0] num_x, num_y;
  logic [spi_pkg::MW-1:0] den;

  spi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pair_i.valid),
    .pts_i   (pts_in),
    .tol_i   (par_tol_q),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den)
  );

  logic [spi_pkg::QW-1:0] quo_x, quo_y;
  logic                   rnz_x, rnz_y;

  spi_div u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (num_x),
    .den_i    (den),
    .quo_o    (quo_x),
    .rem_nz_o (rnz_x)
  );

  spi_div u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (num_y),
    .den_i    (den),
    .quo_o    (quo_y),
    .rem_nz_o (rnz_y)
  );

  // decision and endpoints ride alongside the divider stages
  spi_pkg::side_t           side_q [spi_pkg::DS];
  logic [spi_pkg::DS-1:0]   dv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= fr_side;
      for (int s = 1; s < spi_pkg::DS; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[spi_pkg::DS-2:0], fr_valid};
    end
  end

  spi_snap u_snap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_q[spi_pkg::DS-1]),
    .side_i  (side_q[spi_pkg::DS-1]),
    .quo_x_i (quo_x),
    .rnz_x_i (rnz_x),
    .quo_y_i (quo_y),
    .rnz_y_i (rnz_y),
    .snap_i  (snap_dsq_q),
    .valid_o (result_o.valid),
    .hit_o   (result_o.hit_count),
    .x_o     (result_o.point_x),
    .y_o     (result_o.point_y)
  );

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the segment pair intersection pipeline
`timescale 1ns / 1ps

module testbench;

  // expected outcome of one segment pair
  typedef struct {
    logic [1:0]         hit;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } meet_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spi_pkg::IW-1:0] cfg_idx_i = '0;
  logic [spi_pkg::CW-1:0] cfg_data_i = '0;

  spi_in_if pair_if();
  spi_out_if res_if();

  segment_pair_intersection u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .pair_i(pair_if),
    .result_o(res_if),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // local copy of the configuration
  logic [31:0] tol_q = spi_pkg::PAR_TOL_RST;
  logic [31:0] snap_q = spi_pkg::SNAP_DSQ_RST;

  meet_t pending_meets[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // exact squared sine test: c^2 * 2^32 > tol * p * q
  function automatic bit beyond_tol(longint unsigned c, longint unsigned p,
                                    longint unsigned q);
    logic [191:0] lhs;
    logic [191:0] rhs;
    lhs = c;
    lhs = (lhs * c) << 32;
    rhs = tol_q;
    rhs = rhs * p;
    rhs = rhs * q;
    return lhs > rhs;
  endfunction

  // floor(n * d * 2^16 / k)
  function automatic longint scaled_offset(longint unsigned n, longint d,
                                           longint unsigned k);
    logic [191:0] num;
    logic [191:0] quo;
    logic [191:0] rem;
    num = n;
    num = (num * mag(d)) << spi_pkg::FB;
    quo = num / k;
    rem = num % k;
    if (d < 0) return -(longint'(quo[63:0]) + (rem != 0 ? 1 : 0));
    return longint'(quo[63:0]);
  endfunction

  function automatic bit near_pt(longint px, longint py, longint qx, longint qy);
    longint unsigned dx;
    longint unsigned dy;
    dx = mag(px - qx);
    dy = mag(py - qy);
    if (dx >= 65536 || dy >= 65536) return 1'b0;
    return dx * dx + dy * dy < longint'(snap_q);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // how the two segments meet, from the current register copy
  function automatic meet_t predict_meet(spi_pkg::pts_t s);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, ex, ey, kross, sn, tn, k;
    longint p0, p1, lo, hi, px, py;
    longint unsigned la, lb, le;
    meet_t m;
    ax0 = s.ax0; ay0 = s.ay0; ax1 = s.ax1; ay1 = s.ay1;
    bx0 = s.bx0; by0 = s.by0; bx1 = s.bx1; by1 = s.by1;
    dax = ax1 - ax0; day = ay1 - ay0;
    dbx = bx1 - bx0; dby = by1 - by0;
    ex = bx0 - ax0; ey = by0 - ay0;
    kross = dax * dby - day * dbx;
    la = dax * dax + day * day;
    lb = dbx * dbx + dby * dby;
    le = ex * ex + ey * ey;
    m.hit = spi_pkg::HIT_NONE;
    px = 0;
    py = 0;
    if (beyond_tol(mag(kross), la, lb)) begin
      sn = ex * dby - ey * dbx;
      tn = ex * day - ey * dax;
      k = kross;
      if (k < 0) begin
        k = -k; sn = -sn; tn = -tn;
      end
      if (sn >= 0 && sn <= k && tn >= 0 && tn <= k) begin
        px = ax0 * 65536 + scaled_offset(sn, dax, k);
        py = ay0 * 65536 + scaled_offset(sn, day, k);
        // snap to the first endpoint in range
        if (near_pt(px, py, ax0 * 65536, ay0 * 65536)) begin
          px = ax0 * 65536; py = ay0 * 65536;
        end else if (near_pt(px, py, ax1 * 65536, ay1 * 65536)) begin
          px = ax1 * 65536; py = ay1 * 65536;
        end else if (near_pt(px, py, bx0 * 65536, by0 * 65536)) begin
          px = bx0 * 65536; py = by0 * 65536;
        end else if (near_pt(px, py, bx1 * 65536, by1 * 65536)) begin
          px = bx1 * 65536; py = by1 * 65536;
        end
        m.hit = spi_pkg::HIT_POINT;
      end
    end else if (la != 0 && !beyond_tol(mag(ex * day - ey * dax), la, le)) begin
      // collinear: project b onto a
      p0 = dax * ex + day * ey;
      p1 = dax * (bx1 - ax0) + day * (by1 - ay0);
      lo = p0 < p1 ? p0 : p1;
      hi = p0 < p1 ? p1 : p0;
      if (lo > longint'(la) || hi < 0) begin
        m.hit = spi_pkg::HIT_NONE;
      end else if (lo == longint'(la)) begin
        m.hit = spi_pkg::HIT_POINT; px = ax1 * 65536; py = ay1 * 65536;
      end else if (hi == 0) begin
        m.hit = spi_pkg::HIT_POINT; px = ax0 * 65536; py = ay0 * 65536;
      end else begin
        m.hit = spi_pkg::HIT_OVERLAP;
      end
    end
    if (m.hit != spi_pkg::HIT_POINT) begin
      px = 0; py = 0;
    end
    m.px = sat32(px);
    m.py = sat32(py);
    return m;
  endfunction

  function automatic spi_pkg::pts_t mk_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
    spi_pkg::pts_t s;
    s.ax0 = ax0[15:0]; s.ay0 = ay0[15:0]; s.ax1 = ax1[15:0]; s.ay1 = ay1[15:0];
    s.bx0 = bx0[15:0]; s.by0 = by0[15:0]; s.bx1 = bx1[15:0]; s.by1 = by1[15:0];
    return s;
  endfunction

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // random pair: mostly crossings and collinear layouts, some raw noise
  function automatic spi_pkg::pts_t rand_pair();
    spi_pkg::pts_t s;
    int kind, r, x0, y0, dx, dy, m, k0, k1;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        s = {$urandom, $urandom, $urandom, $urandom};
      end
      2, 3, 4: begin
        case ($urandom_range(2))
          0: r = 15;
          1: r = 300;
          default: r = 32767;
        endcase
        s = mk_pair(rnd(-r, r), rnd(-r, r), rnd(-r, r), rnd(-r, r),
                    rnd(-r, r), rnd(-r, r), rnd(-r, r), rnd(-r, r));
      end
      5, 6, 7: begin
        x0 = rnd(-2000, 2000); y0 = rnd(-2000, 2000);
        dx = rnd(-20, 20); dy = rnd(-20, 20);
        m = rnd(1, 50);
        k0 = rnd(-60, 110); k1 = rnd(-60, 110);
        case ($urandom_range(3))
          0: k0 = m;
          1: k1 = 0;
          default: ;
        endcase
        s = mk_pair(x0, y0, x0 + m * dx, y0 + m * dy,
                    x0 + k0 * dx, y0 + k0 * dy, x0 + k1 * dx, y0 + k1 * dy);
        // occasionally push b slightly off the line
        if ($urandom_range(4) == 0) s.by0 = s.by0 + 16'sd1;
      end
      8: begin
        s = {$urandom, $urandom, $urandom, $urandom};
        s.bx0 = s.ax1; s.by0 = s.ay1;
        if ($urandom_range(1)) begin
          s.bx0 = s.ax0; s.by0 = s.ay0;
        end
      end
      default: begin
        s = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(1)) begin
          s.ax1 = s.ax0; s.ay1 = s.ay0;
        end else begin
          s.bx1 = s.bx0; s.by1 = s.by0;
        end
      end
    endcase
    return s;
  endfunction

  // send one item, entered and left at a falling edge
  task automatic send_pair(spi_pkg::pts_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      pair_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pair_if.valid = 1'b1;
    pair_if.a_start_x = s.ax0; pair_if.a_start_y = s.ay0;
    pair_if.a_end_x = s.ax1; pair_if.a_end_y = s.ay1;
    pair_if.b_start_x = s.bx0; pair_if.b_start_y = s.by0;
    pair_if.b_end_x = s.bx1; pair_if.b_end_y = s.by1;
    @(posedge clk_i);
    while (!pair_if.ready) @(posedge clk_i);
    pending_meets = {pending_meets, predict_meet(s)};
    @(negedge clk_i);
  endtask

  // stop sending and let the pipeline empty
  task automatic drain();
    pair_if.valid = 1'b0;
    while (pending_meets.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [spi_pkg::IW-1:0] idx, logic [spi_pkg::CW-1:0] data);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    if (idx == spi_pkg::REG_PAR_TOL) tol_q = data;
    else snap_q = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_random(int n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_pair(rand_pair());
  endtask

  // hand-picked geometry at the current register settings
  task automatic test_directed();
    send_pair(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    send_pair(mk_pair(5, 5, 5, 5, 0, 0, 10, 10));
    send_pair(mk_pair(0, 0, 10, 0, 3, 0, 3, 0));
    send_pair(mk_pair(0, 0, 10, 0, 20, 5, 20, 5));
    send_pair(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(mk_pair(0, 0, 10, 0, 10, 0, 20, 0));
    send_pair(mk_pair(0, 0, 10, 0, -7, 0, 0, 0));
    send_pair(mk_pair(0, 0, 10, 0, 11, 0, 20, 0));
    send_pair(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(mk_pair(0, 0, 10, 0, 20, 0, -20, 0));
    send_pair(mk_pair(0, 0, 3, 7, 1, 0, 0, 5));
    send_pair(mk_pair(0, 0, 10, 0, 10, 0, 10, 9));
    send_pair(mk_pair(0, 0, 10, 0, 11, -1, 11, 1));
    send_pair(mk_pair(-1, -1, 2, 1, 1, -2, -1, 3));
    send_pair(mk_pair(0, 0, 32767, 1, 0, 1, 32767, 0));
    send_pair(mk_pair(0, 0, 1000, 1, 0, 0, -1000, 1));
  endtask

  task automatic test_reset_settings();
    send_random(300, 0, 0);
    send_random(150, 58, 0);
    // sender holds off until every result is back
    drain();
    send_random(150, 58, 0);
  endtask

  task automatic test_tolerance_extremes();
    write_reg(spi_pkg::REG_PAR_TOL, 32'd0);
    test_directed();
    send_random(150, 0, 58);
    write_reg(spi_pkg::REG_PAR_TOL, 32'hffffffff);
    test_directed();
    send_random(150, 33, 33);
    write_reg(spi_pkg::REG_PAR_TOL, $urandom);
    send_random(100, 0, 58);
    write_reg(spi_pkg::REG_PAR_TOL, 32'h0100_0000);
    send_random(100, 33, 33);
  endtask

  task automatic test_snap_extremes();
    write_reg(spi_pkg::REG_PAR_TOL, spi_pkg::PAR_TOL_RST);
    write_reg(spi_pkg::REG_SNAP_DSQ, 32'd0);
    test_directed();
    send_random(150, 0, 0);
    write_reg(spi_pkg::REG_SNAP_DSQ, 32'hffffffff);
    test_directed();
    send_random(150, 33, 33);
    write_reg(spi_pkg::REG_SNAP_DSQ, $urandom_range(32'h4000_0000));
    send_random(150, 58, 0);
    write_reg(spi_pkg::REG_SNAP_DSQ, spi_pkg::SNAP_DSQ_RST);
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    res_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    meet_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_meets.size() == 0) begin
        $display("%0t: unexpected result hit=%0d x=%h y=%h", $time,
                 res_if.hit_count, res_if.point_x, res_if.point_y);
        mismatches++;
      end else begin
        want = pending_meets.pop_front();
        if (res_if.hit_count !== want.hit || res_if.point_x !== want.px ||
            res_if.point_y !== want.py) begin
          $display("%0t: mismatch expected hit=%0d x=%h y=%h got hit=%0d x=%h y=%h",
                   $time, want.hit, want.px, want.py,
                   res_if.hit_count, res_if.point_x, res_if.point_y);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pair_if.valid = 1'b0;
    pair_if.a_start_x = '0; pair_if.a_start_y = '0;
    pair_if.a_end_x = '0; pair_if.a_end_y = '0;
    pair_if.b_start_x = '0; pair_if.b_start_y = '0;
    pair_if.b_end_x = '0; pair_if.b_end_y = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_reset_settings();
    test_tolerance_extremes();
    test_snap_extremes();
    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
